### design/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg
// shared widths, reset values, codes and state type of the cat map scrambler
// ----------------------------------------------------------------------------
package csm_pkg;

  localparam int PIXEL_W          = 24;
  localparam int POS_IN_W         = 8;
  localparam int SIDE_W           = 9;
  localparam int ITER_W           = 10;
  localparam int CFG_DATA_W       = 10;
  localparam int SIDE_MIN         = 2;
  localparam int SIDE_MAX_DEFAULT = 256;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 9'd240;
  localparam logic [ITER_W-1:0] ITER_RESET = 10'd30;

  // input action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef enum logic [0:0] {
    REG_SIDE_LENGTH    = 1'b0,
    REG_MAP_ITERATIONS = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MAP,
    ST_PLACE,
    ST_FETCH,
    ST_COMPARE
  } csm_state_t;

endpackage

### design/csm_store.sv
// ----------------------------------------------------------------------------
// csm_store
// single-port-write, single-port-read pixel memory, registered read data
// ----------------------------------------------------------------------------
module csm_store #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [csm_pkg::PIXEL_W-1:0] wdata,
  input  logic                        re,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [csm_pkg::PIXEL_W-1:0] rdata
);
  import csm_pkg::*;

  logic [PIXEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/csm_mod.sv
// ----------------------------------------------------------------------------
// csm_mod
// bit-serial remainder of an 8-bit position by the side length
// ----------------------------------------------------------------------------
module csm_mod #(
  parameter int POS_W = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [csm_pkg::POS_IN_W-1:0] num,
  input  logic [csm_pkg::SIDE_W-1:0]   den,
  output logic                         done,
  output logic [POS_W-1:0]             result
);
  import csm_pkg::*;

  localparam int CNT_W = $clog2(POS_IN_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [POS_IN_W-1:0] num_sh;
  logic [SIDE_W-1:0]  rem;
  logic [SIDE_W:0]    trial;
  logic [SIDE_W:0]    rem_next;

  always_comb begin
    trial = {rem, num_sh[POS_IN_W-1]};
    if (trial >= {1'b0, den}) begin
      rem_next = trial - {1'b0, den};
    end else begin
      rem_next = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(POS_IN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder stays below den, so it fits the side width
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      num_sh <= num;
    end else if (busy) begin
      rem    <= rem_next[SIDE_W-1:0];
      num_sh <= {num_sh[POS_IN_W-2:0], 1'b0};
    end
  end

  assign result = POS_W'(rem);

endmodule

### design/csm_step.sv
// ----------------------------------------------------------------------------
// csm_step
// cat map iterator, one map step per cycle for the configured count
// ----------------------------------------------------------------------------
module csm_step #(
  parameter int POS_W = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [csm_pkg::SIDE_W-1:0] side,
  input  logic [csm_pkg::ITER_W-1:0] iterations,
  input  logic [POS_W-1:0]           row0,
  input  logic [POS_W-1:0]           col0,
  output logic                       done,
  output logic [POS_W-1:0]           dr,
  output logic [POS_W-1:0]           dc
);
  import csm_pkg::*;

  localparam int CW = ((POS_W > SIDE_W) ? POS_W : SIDE_W) + 1;

  logic              busy;
  logic [ITER_W-1:0] cnt;
  logic [CW-1:0]     sum_r;
  logic [CW-1:0]     sum_c;
  logic [CW-1:0]     nr;
  logic [CW-1:0]     nc;

  // (r+2c) mod s is the same as (nr+c) mod s, so each sum stays below 2s
  always_comb begin
    sum_r = CW'(dr) + CW'(dc);
    nr    = (sum_r >= CW'(side)) ? sum_r - CW'(side) : sum_r;
    sum_c = nr + CW'(dc);
    nc    = (sum_c >= CW'(side)) ? sum_c - CW'(side) : sum_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == iterations) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dr <= row0;
      dc <= col0;
    end else if (busy && (cnt != iterations)) begin
      dr <= nr[POS_W-1:0];
      dc <= nc[POS_W-1:0];
    end
  end

endmodule

### design/cat_map_image_scrambler_unit.sv
// ----------------------------------------------------------------------------
// cat_map_image_scrambler_unit
// arnold cat map image scrambler with per-pixel period check
// ----------------------------------------------------------------------------
// A write request stores its pixel as the original at (row, col) and places it
// in the scrambled image at the position reached after map_iterations steps of
// (r,c) -> ((r+c) mod side, (r+2c) mod side); the response reports that
// position. A read request returns the scrambled pixel at (row, col) and flags
// whether it equals the original pixel there. Positions are first reduced
// modulo the side by a bit-serial remainder unit (row and column in
// parallel), then a write runs one map step per cycle and loads the response
// in the place state, while a read fetches both pixels and loads it in the
// compare state; either waits there while a previous response is still held.
// The next request is taken once the unit is back in idle after the response
// is loaded, and one request is in flight at a time. side_length is
// clamped to the range 2..SIDE_MAX. Both images live in block memories with no
// reset: reading a pixel that was never written returns undefined data.
// Configuration writes are taken only while no request is in flight and go
// ahead of a request offered in the same cycle.
// ----------------------------------------------------------------------------
module cat_map_image_scrambler_unit #(
  parameter int SIDE_MAX = csm_pkg::SIDE_MAX_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // request stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [39:0]                    s_tdata,   // row[7:0], col[15:8], pixel_value[39:16]
  input  logic [0:0]                     s_tuser,   // action[0]
  // response stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [47:0]                    m_tdata,   // read_pixel[23:0], matches_original[24],
                                                    // dest_row[32:25], dest_col[40:33], zero
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [0:0]                     cfg_index,
  input  logic [csm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import csm_pkg::*;

  localparam int POS_W  = (SIDE_MAX > 2) ? $clog2(SIDE_MAX) : 1;
  localparam int DEPTH  = SIDE_MAX * SIDE_MAX;
  localparam int ADDR_W = $clog2(DEPTH);

  // configuration registers
  logic [SIDE_W-1:0] side_length;
  logic [ITER_W-1:0] map_iterations;
  logic [SIDE_W-1:0] side_use;

  // request registers
  csm_state_t         state;
  csm_state_t         state_next;
  logic               action;
  logic [PIXEL_W-1:0] pixel;

  // response register
  logic               out_valid;
  logic [PIXEL_W-1:0] out_pixel;
  logic               out_match;
  logic [POS_IN_W-1:0] out_row;
  logic [POS_IN_W-1:0] out_col;
  logic               out_free;
  logic               load_write;
  logic               load_read;

  // unit hookups
  logic               accept;
  logic               mod_done;
  logic               mod_done_c;
  logic [POS_W-1:0]   row_red;
  logic [POS_W-1:0]   col_red;
  logic               step_start;
  logic               step_done;
  logic [POS_W-1:0]   dr;
  logic [POS_W-1:0]   dc;

  // memory hookups
  logic               mem_we;
  logic               mem_re;
  logic [ADDR_W-1:0]  src_addr;
  logic [ADDR_W-1:0]  dst_addr;
  logic [PIXEL_W-1:0] scr_rdata;
  logic [PIXEL_W-1:0] org_rdata;

  // config port ready while idle, side clamped once here
  assign cfg_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      side_length    <= SIDE_RESET;
      map_iterations <= ITER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_e'(cfg_index))
        REG_SIDE_LENGTH:    side_length    <= cfg_data[SIDE_W-1:0];
        REG_MAP_ITERATIONS: map_iterations <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (side_length < SIDE_W'(SIDE_MIN)) begin
      side_use = SIDE_W'(SIDE_MIN);
    end else if ((SIDE_W + 2)'(side_length) > (SIDE_W + 2)'(SIDE_MAX)) begin
      side_use = SIDE_W'(SIDE_MAX);
    end else begin
      side_use = side_length;
    end
  end

  // request intake, a pending register write goes first
  assign s_tready = (state == ST_IDLE) && !cfg_valid;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      action <= s_tuser[0];
      pixel  <= s_tdata[39:16];
    end
  end

  // position reduction, row and column in lockstep
  csm_mod #(.POS_W(POS_W)) u_mod_row (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .num    (s_tdata[7:0]),
    .den    (side_use),
    .done   (mod_done),
    .result (row_red)
  );

  csm_mod #(.POS_W(POS_W)) u_mod_col (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .num    (s_tdata[15:8]),
    .den    (side_use),
    .done   (mod_done_c),
    .result (col_red)
  );

  // map walk for writes
  csm_step #(.POS_W(POS_W)) u_step (
    .clk        (clk),
    .rst        (rst),
    .start      (step_start),
    .side       (side_use),
    .iterations (map_iterations),
    .row0       (row_red),
    .col0       (col_red),
    .done       (step_done),
    .dr         (dr),
    .dc         (dc)
  );

  // row-major address, row scaled by the store pitch
  assign src_addr = ADDR_W'(row_red * SIDE_MAX) + ADDR_W'(col_red);
  assign dst_addr = ADDR_W'(dr * SIDE_MAX) + ADDR_W'(dc);

  // image stores: both written together on a placed write, read together
  csm_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_scrambled (
    .clk   (clk),
    .we    (mem_we),
    .waddr (dst_addr),
    .wdata (pixel),
    .re    (mem_re),
    .raddr (src_addr),
    .rdata (scr_rdata)
  );

  csm_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_original (
    .clk   (clk),
    .we    (mem_we),
    .waddr (src_addr),
    .wdata (pixel),
    .re    (mem_re),
    .raddr (src_addr),
    .rdata (org_rdata)
  );

  // sequencer
  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    step_start = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    load_write = 1'b0;
    load_read  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mod_done && mod_done_c) begin
          if (action == ACT_WRITE) begin
            step_start = 1'b1;
            state_next = ST_MAP;
          end else begin
            state_next = ST_FETCH;
          end
        end
      end
      ST_MAP: begin
        if (step_done) begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        // wait for the response slot, then commit both stores at once
        if (out_free) begin
          mem_we     = 1'b1;
          load_write = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FETCH: begin
        mem_re     = 1'b1;
        state_next = ST_COMPARE;
      end
      ST_COMPARE: begin
        // read data holds while no new read is issued
        if (out_free) begin
          load_read  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_write || load_read) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_write) begin
      out_pixel <= '0;
      out_match <= 1'b0;
      out_row   <= POS_IN_W'(dr);
      out_col   <= POS_IN_W'(dc);
    end else if (load_read) begin
      out_pixel <= scr_rdata;
      out_match <= (scr_rdata == org_rdata);
      out_row   <= '0;
      out_col   <= '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_col, out_row, out_match, out_pixel};

endmodule
